@@ src/tdq_pkg.sv @@
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared constants, codes and types of the tail-drop transmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int HANDLE_BITS = 16;

	localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int CAP_W  = 7;
	localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int OP_W   = 2;
	localparam int ROUTE_W = 2;
	localparam int HDL_W  = 16;
	localparam int DROP_W = 32;
	localparam int QLEN_W = 7;

	localparam logic [OP_W-1:0] OP_UPPER   = 2'd0;
	localparam logic [OP_W-1:0] OP_TX_DONE = 2'd1;
	localparam logic [OP_W-1:0] OP_LINE    = 2'd2;

	localparam logic [ROUTE_W-1:0] ROUTE_LINE  = 2'd0;
	localparam logic [ROUTE_W-1:0] ROUTE_UPPER = 2'd1;
	localparam logic [ROUTE_W-1:0] ROUTE_DROP  = 2'd2;

	typedef struct packed {
		logic               valid;
		logic [ROUTE_W-1:0] route;
		logic [HDL_W-1:0]   handle;
		logic [DROP_W-1:0]  drops;
		logic [QLEN_W-1:0]  qlen;
	} res_t;

endpackage

`default_nettype wire

@@ src/tail_drop_tx_queue.sv @@
// ----------------------------------------------------------------------------
// tail_drop_tx_queue
// Tail-drop FIFO output queue in front of a transmitter.
// ----------------------------------------------------------------------------
// Each input request is an event: opcode 0 hands down a packet, opcode 1 tells
// that the transmitter finished, opcode 2 brings a packet up from the line.
// A packet goes straight to the line when the transmitter is idle, is queued
// in the packet store while it is busy, and is dropped once the queue holds
// capacity entries (capacity 0, or one above the store depth, means the whole store).
// A transmit-done that pops a queued packet holds off the next event while
// the packet store, a synchronous RAM, gives its read data in the cycle
// after the head address is presented. One result register sits on the output
// side, so a new event is taken in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_tx_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [tdq_pkg::CAP_W-1:0]     cfg_wdata,   // capacity
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,     // packet_handle
	input  wire logic [tdq_pkg::OP_W-1:0]      s_tuser,     // opcode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [55:0]                        m_tdata,     // packet_handle_res, drop_count, queue_length
	output logic [tdq_pkg::ROUTE_W-1:0]        m_tuser      // route
);

	tdq_pkg::res_t res;
	logic          out_free;

	tdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_handle (s_tdata),
		.out_free  (out_free),
		.res       (res)
	);

	tdq_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ src/tdq_ram.sv @@
// ----------------------------------------------------------------------------
// tdq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/tdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdq_ctrl
// Queue control: pointers, fill count, transmitter state, drop counter and
// the enqueue writes and pop reads on the packet store.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [tdq_pkg::CAP_W-1:0]    cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [tdq_pkg::OP_W-1:0]     in_op,
	input  wire logic [tdq_pkg::HDL_W-1:0]    in_handle,
	input  wire logic                         out_free,
	output tdq_pkg::res_t                     res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                               state_q;
	logic [tdq_pkg::CAP_W-1:0]          capacity_q;
	logic [tdq_pkg::PTR_W-1:0]          head_q;
	logic [tdq_pkg::PTR_W-1:0]          tail_q;
	logic [tdq_pkg::CNT_W-1:0]          count_q;
	logic                               busy_q;
	logic [tdq_pkg::DROP_W-1:0]         drops_q;

	logic                               acc;
	logic [tdq_pkg::LIM_W-1:0]          limit;
	logic                               full;
	logic [tdq_pkg::DROP_W-1:0]         drops_inc;
	logic [tdq_pkg::PTR_W-1:0]          head_inc;
	logic [tdq_pkg::PTR_W-1:0]          tail_inc;
	logic [tdq_pkg::HANDLE_BITS-1:0]    handle_m;
	logic [tdq_pkg::HANDLE_BITS-1:0]    rd_data;

	logic                               ram_we;
	logic                               ram_re;

	logic                               state_d;
	logic [tdq_pkg::PTR_W-1:0]          head_d;
	logic [tdq_pkg::PTR_W-1:0]          tail_d;
	logic [tdq_pkg::CNT_W-1:0]          count_d;
	logic                               busy_d;
	logic [tdq_pkg::DROP_W-1:0]         drops_d;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign handle_m = tdq_pkg::HANDLE_BITS'(in_handle);

	always_comb begin
		if ((capacity_q == '0) ||
		    (tdq_pkg::LIM_W'(capacity_q) > tdq_pkg::LIM_W'(tdq_pkg::STORE_DEPTH))) begin
			limit = tdq_pkg::LIM_W'(tdq_pkg::STORE_DEPTH);
		end else begin
			limit = tdq_pkg::LIM_W'(capacity_q);
		end
	end

	assign full      = tdq_pkg::LIM_W'(count_q) >= limit;
	assign drops_inc = (drops_q == '1) ? drops_q : drops_q + tdq_pkg::DROP_W'(1);
	assign head_inc  = (head_q == tdq_pkg::PTR_W'(tdq_pkg::STORE_DEPTH - 1)) ? '0 :
	                   head_q + tdq_pkg::PTR_W'(1);
	assign tail_inc  = (tail_q == tdq_pkg::PTR_W'(tdq_pkg::STORE_DEPTH - 1)) ? '0 :
	                   tail_q + tdq_pkg::PTR_W'(1);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		busy_d     = busy_q;
		drops_d    = drops_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		res.valid  = 1'b0;
		res.route  = tdq_pkg::ROUTE_LINE;
		res.handle = tdq_pkg::HDL_W'(handle_m);
		res.drops  = drops_q;
		res.qlen   = tdq_pkg::QLEN_W'(count_q);
		if (state_q == ST_READ) begin
			state_d    = ST_IDLE;
			res.valid  = 1'b1;
			res.route  = tdq_pkg::ROUTE_LINE;
			res.handle = tdq_pkg::HDL_W'(rd_data);
		end else if (acc) begin
			unique case (in_op)
				tdq_pkg::OP_UPPER: begin
					if (!busy_q) begin
						busy_d    = 1'b1;
						res.valid = 1'b1;
						res.route = tdq_pkg::ROUTE_LINE;
					end else if (full) begin
						drops_d   = drops_inc;
						res.valid = 1'b1;
						res.route = tdq_pkg::ROUTE_DROP;
						res.drops = drops_inc;
					end else begin
						ram_we  = 1'b1;
						tail_d  = tail_inc;
						count_d = count_q + tdq_pkg::CNT_W'(1);
					end
				end
				tdq_pkg::OP_TX_DONE: begin
					busy_d = 1'b0;
					if (count_q != '0) begin
						ram_re  = 1'b1;
						head_d  = head_inc;
						count_d = count_q - tdq_pkg::CNT_W'(1);
						busy_d  = 1'b1;
						state_d = ST_READ;
					end
				end
				tdq_pkg::OP_LINE: begin
					res.valid = 1'b1;
					res.route = tdq_pkg::ROUTE_UPPER;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			busy_q     <= 1'b0;
			drops_q    <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			busy_q  <= busy_d;
			drops_q <= drops_d;
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
		end
	end

	tdq_ram #(
		.WIDTH (tdq_pkg::HANDLE_BITS),
		.DEPTH (tdq_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (handle_m),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (rd_data)
	);

endmodule

`default_nettype wire

@@ src/tdq_out_stage.sv @@
// ----------------------------------------------------------------------------
// tdq_out_stage
// Output register holding one result request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_out_stage (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tdq_pkg::res_t                 res,
	output logic                               out_free,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [55:0]                        m_tdata,
	output logic [tdq_pkg::ROUTE_W-1:0]        m_tuser
);

	logic                          valid_q;
	logic [tdq_pkg::ROUTE_W-1:0]   route_q;
	logic [tdq_pkg::HDL_W-1:0]     handle_q;
	logic [tdq_pkg::DROP_W-1:0]    drops_q;
	logic [tdq_pkg::QLEN_W-1:0]    qlen_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			route_q  <= res.route;
			handle_q <= res.handle;
			drops_q  <= res.drops;
			qlen_q   <= res.qlen;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = route_q;
	assign m_tdata  = {1'b0, qlen_q, drops_q, handle_q};

endmodule

`default_nettype wire
